FILE: src/msip_pkg.sv
package msip_pkg;

    localparam int BUFFER_DEPTH_DEF = 128;

    // MIDI byte codes
    localparam logic [7:0] B_SOX     = 8'hF0;
    localparam logic [7:0] B_EOX     = 8'hF7;
    localparam logic [7:0] B_NONRT   = 8'h7E;
    localparam logic [7:0] B_BCAST   = 8'h7F;
    localparam logic [7:0] B_GENINFO = 8'h06;
    localparam logic [7:0] B_IDREPLY = 8'h02;
    localparam logic [7:0] B_MAN3    = 8'h00;

    // result status codes
    localparam logic [1:0] STAT_REPLY    = 2'd0;
    localparam logic [1:0] STAT_OTHER    = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW = 2'd2;

    // message layout
    localparam int HDR_LEN = 5;
    localparam int MAN_POS = 5;
    localparam int LEN_MIN = 6;
    localparam int LEN_STD = 15;
    localparam int LEN_EXT = 17;

    // decode walks addresses 0..RD_LAST, fields are bytes MAN_POS..RD_LAST
    localparam int          RD_IDX_W = 4;
    localparam logic [3:0]  RD_LAST  = 4'd15;
    localparam int          FLD_N    = 11;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EMIT
    } t_state;

    function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
        logic [7:0] b;
        unique case (pos)
            3'd0:    b = B_SOX;
            3'd1:    b = B_NONRT;
            3'd2:    b = B_BCAST;
            3'd3:    b = B_GENINFO;
            3'd4:    b = B_IDREPLY;
            default: b = B_SOX;
        endcase
        return b;
    endfunction

endpackage

FILE: src/msip_ram.sv
module msip_ram
    import msip_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = BUFFER_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/midi_sysex_identity_parser.sv
// MIDI SysEx identity-reply parser.
// Input channel: one MIDI byte per transaction (i_valid / o_stall). Output
// channel: one result per ended message (o_valid / i_stall), carrying a
// status (identity reply, other message, overflow) and the decoded reply
// fields, which read zero unless the status is identity reply.
// Bytes of a message are written into a single-port-write, registered-read
// buffer of BUFFER_DEPTH bytes. A data, start or ignored byte does not stall.
// A byte that ends a message starts a decode that reads buffer addresses
// 0 to 15 one per cycle; the next byte is taken once the last read has
// returned and the result is loaded. An overflow result is loaded after
// the offending byte, which is not stored, once the output register is free.
// o_stall is high while a decode or result load is in progress. The result
// sits in an output register, so new bytes are taken while it waits; a
// further result is held back until the receiver has taken the previous
// one. Reset returns the parser to idle with an empty buffer and no result
// pending; the buffer needs no clearing pass since only written bytes are
// ever decoded.
module midi_sysex_identity_parser
    import msip_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_midi_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic        o_man_extended,
    output logic [13:0] o_manufacturer,
    output logic [13:0] o_family,
    output logic [13:0] o_model,
    output logic [6:0]  o_version_a,
    output logic [6:0]  o_version_b,
    output logic [6:0]  o_version_c,
    output logic [6:0]  o_version_d
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    t_state              r_state, n_state;
    logic                r_cap, n_cap;
    logic [CW-1:0]       r_count, n_count;
    logic                r_ovf, n_ovf;
    logic [RD_IDX_W-1:0] r_idx, n_idx;
    logic                r_pend, n_pend;
    logic [RD_IDX_W-1:0] r_pend_pos;
    logic                r_hdr_ok, n_hdr_ok;
    logic                r_ext, n_ext;
    logic [6:0]          r_fld [FLD_N];

    logic                r_o_valid;
    logic [1:0]          r_o_status;
    logic                r_o_ext;
    logic [13:0]         r_o_man, r_o_fam, r_o_model;
    logic [6:0]          r_o_va, r_o_vb, r_o_vc, r_o_vd;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [7:0]          ram_rdata;

    logic                is_rt, is_sox, is_end, is_data, full, pend_in_msg, out_load;
    logic                res_ok;
    logic [13:0]         res_man, res_fam, res_model;
    logic [6:0]          res_va, res_vb, res_vc, res_vd;

    msip_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_midi_byte),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign is_rt   = i_midi_byte > B_EOX;
    assign is_sox  = i_midi_byte == B_SOX;
    assign is_data = !i_midi_byte[7];
    assign is_end  = !is_rt && !is_sox && ((i_midi_byte == B_EOX) || (i_midi_byte[7] && r_cap));
    assign full    = r_count == CW'(BUFFER_DEPTH);
    assign pend_in_msg = r_pend && (CW'(r_pend_pos) < r_count);
    assign ram_raddr   = AW'(r_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cap     = r_cap;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_idx     = r_idx;
        n_pend    = 1'b0;
        n_hdr_ok  = r_hdr_ok;
        n_ext     = r_ext;
        ram_we    = 1'b0;
        ram_waddr = r_count[AW-1:0];
        out_load  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (is_sox) begin
                        if (!r_cap) begin
                            ram_we    = 1'b1;
                            ram_waddr = '0;
                            n_count   = CW'(1);
                            n_cap     = 1'b1;
                        end
                    end else if (is_end || (is_data && r_cap)) begin
                        if (full) begin
                            n_ovf   = 1'b1;
                            n_cap   = 1'b0;
                            n_count = '0;
                            n_state = S_EMIT;
                        end else begin
                            ram_we  = 1'b1;
                            n_count = r_count + CW'(1);
                            if (is_end) begin
                                n_cap    = 1'b0;
                                n_ovf    = 1'b0;
                                n_idx    = '0;
                                n_hdr_ok = 1'b1;
                                n_state  = S_READ;
                            end
                        end
                    end
                end
            end
            S_READ: begin
                n_pend = 1'b1;
                n_idx  = r_idx + RD_IDX_W'(1);
                if (r_idx == RD_LAST) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // wait for the last read to return and the output register to free up
                if (!r_pend && (!r_o_valid || !i_stall)) begin
                    out_load = 1'b1;
                    n_count  = '0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // header and manufacturer-form checks only look at stored bytes
        if (pend_in_msg) begin
            if (r_pend_pos < RD_IDX_W'(HDR_LEN)) begin
                if (ram_rdata != hdr_byte(r_pend_pos[2:0])) begin
                    n_hdr_ok = 1'b0;
                end
            end else if (r_pend_pos == RD_IDX_W'(MAN_POS)) begin
                n_ext = ram_rdata == B_MAN3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= 1'b0;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_idx    <= '0;
            r_pend   <= 1'b0;
            r_hdr_ok <= 1'b0;
            r_ext    <= 1'b0;
        end else begin
            r_cap    <= n_cap;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_idx    <= n_idx;
            r_pend   <= n_pend;
            r_hdr_ok <= n_hdr_ok;
            r_ext    <= n_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_pos <= r_idx;
        if (r_pend && (r_pend_pos >= RD_IDX_W'(MAN_POS))) begin
            r_fld[RD_IDX_W'(r_pend_pos - RD_IDX_W'(MAN_POS))] <= ram_rdata[6:0];
        end
    end

    assign res_ok = !r_ovf && r_hdr_ok && (r_count >= CW'(LEN_MIN))
                  && (r_ext ? (r_count >= CW'(LEN_EXT)) : (r_count >= CW'(LEN_STD)));

    always_comb begin
        res_man   = '0;
        res_fam   = '0;
        res_model = '0;
        res_va    = '0;
        res_vb    = '0;
        res_vc    = '0;
        res_vd    = '0;
        if (res_ok) begin
            if (r_ext) begin
                // extended id: 00, high byte, low byte
                res_man   = {r_fld[1], r_fld[2]};
                res_fam   = {r_fld[4], r_fld[3]};
                res_model = {r_fld[6], r_fld[5]};
                res_va    = r_fld[7];
                res_vb    = r_fld[8];
                res_vc    = r_fld[9];
                res_vd    = r_fld[10];
            end else begin
                res_man   = {7'd0, r_fld[0]};
                res_fam   = {r_fld[2], r_fld[1]};
                res_model = {r_fld[4], r_fld[3]};
                res_va    = r_fld[5];
                res_vb    = r_fld[6];
                res_vc    = r_fld[7];
                res_vd    = r_fld[8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_status <= r_ovf ? STAT_OVERFLOW : (res_ok ? STAT_REPLY : STAT_OTHER);
            r_o_ext    <= res_ok && r_ext;
            r_o_man    <= res_man;
            r_o_fam    <= res_fam;
            r_o_model  <= res_model;
            r_o_va     <= res_va;
            r_o_vb     <= res_vb;
            r_o_vc     <= res_vc;
            r_o_vd     <= res_vd;
        end
    end

    assign o_stall        = r_state != S_IDLE;
    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_man_extended = r_o_ext;
    assign o_manufacturer = r_o_man;
    assign o_family       = r_o_fam;
    assign o_model        = r_o_model;
    assign o_version_a    = r_o_va;
    assign o_version_b    = r_o_vb;
    assign o_version_c    = r_o_vc;
    assign o_version_d    = r_o_vd;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(BUFFER_DEPTH))
        else $error("byte count beyond buffer depth");

    a_non_reply_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != STAT_REPLY)) |-> (!o_man_extended && (o_manufacturer == '0)
            && (o_family == '0) && (o_model == '0) && (o_version_a == '0)
            && (o_version_b == '0) && (o_version_c == '0) && (o_version_d == '0)))
        else $error("non-reply result carries field data");

    a_short_man_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == STAT_REPLY) && !o_man_extended)
            |-> (o_manufacturer[13:7] == '0))
        else $error("one-byte manufacturer id wider than seven bits");
`endif

endmodule

FILE: tb/msip_reply_checker.sv
`timescale 1ns / 100ps

module msip_reply_checker
    import msip_pkg::*;
#(
    parameter int DEPTH = BUFFER_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_byte_valid,
    input  logic        i_byte_stall,
    input  logic [7:0]  i_midi_byte,
    input  logic        i_res_valid,
    input  logic        i_res_stall,
    input  logic [1:0]  i_status,
    input  logic        i_man_extended,
    input  logic [13:0] i_manufacturer,
    input  logic [13:0] i_family,
    input  logic [13:0] i_model,
    input  logic [6:0]  i_version_a,
    input  logic [6:0]  i_version_b,
    input  logic [6:0]  i_version_c,
    input  logic [6:0]  i_version_d,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [1:0]  status;
        logic        man_ext;
        logic [13:0] manufacturer;
        logic [13:0] family;
        logic [13:0] model;
        logic [6:0]  ver_a;
        logic [6:0]  ver_b;
        logic [6:0]  ver_c;
        logic [6:0]  ver_d;
    } t_ident_result;

    t_ident_result expected_q[$];

    logic        capturing = 1'b0;
    int unsigned msg_len = 0;
    logic [7:0]  msg_buf [DEPTH];
    int          fails = 0;

    function automatic t_ident_result decode_message();
        t_ident_result r;
        int            p;
        int            need;
        r = '0;
        r.status = STAT_OTHER;
        if (msg_len < LEN_MIN) begin
            return r;
        end
        if (msg_buf[0] != B_SOX || msg_buf[1] != B_NONRT || msg_buf[2] != B_BCAST ||
            msg_buf[3] != B_GENINFO || msg_buf[4] != B_IDREPLY) begin
            return r;
        end
        need = (msg_buf[MAN_POS] == B_MAN3) ? LEN_EXT : LEN_STD;
        // all fields must sit before the terminator
        if (msg_len < need) begin
            return r;
        end
        r.status = STAT_REPLY;
        p = MAN_POS;
        if (msg_buf[p] == B_MAN3) begin
            r.man_ext = 1'b1;
            r.manufacturer = {msg_buf[p + 1][6:0], msg_buf[p + 2][6:0]};
            p += 3;
        end else begin
            r.manufacturer = {7'd0, msg_buf[p][6:0]};
            p += 1;
        end
        r.family = {msg_buf[p + 1][6:0], msg_buf[p][6:0]};
        r.model  = {msg_buf[p + 3][6:0], msg_buf[p + 2][6:0]};
        r.ver_a  = msg_buf[p + 4][6:0];
        r.ver_b  = msg_buf[p + 5][6:0];
        r.ver_c  = msg_buf[p + 6][6:0];
        r.ver_d  = msg_buf[p + 7][6:0];
        return r;
    endfunction

    task automatic parse_byte(input logic [7:0] b);
        t_ident_result r;
        logic          ends;
        if (b > B_EOX) begin
            return;
        end
        if (b == B_SOX) begin
            if (!capturing) begin
                msg_buf[0] = b;
                msg_len = 1;
                capturing = 1'b1;
            end
            return;
        end
        ends = (b == B_EOX) || (b[7] && capturing);
        if (!ends && !capturing) begin
            return;
        end
        if (msg_len >= DEPTH) begin
            r = '0;
            r.status = STAT_OVERFLOW;
            expected_q.push_back(r);
            capturing = 1'b0;
            msg_len = 0;
            return;
        end
        msg_buf[msg_len] = b;
        msg_len++;
        if (ends) begin
            expected_q.push_back(decode_message());
            capturing = 1'b0;
            msg_len = 0;
        end
    endtask

    always @(posedge i_clk) begin
        t_ident_result got;
        t_ident_result want;
        if (!i_rst_n) begin
            capturing = 1'b0;
            msg_len = 0;
            expected_q.delete();
        end else begin
            // results first: nothing leaves the block in the cycle its byte enters
            if (i_res_valid && !i_res_stall) begin
                got.status       = i_status;
                got.man_ext      = i_man_extended;
                got.manufacturer = i_manufacturer;
                got.family       = i_family;
                got.model        = i_model;
                got.ver_a        = i_version_a;
                got.ver_b        = i_version_b;
                got.ver_c        = i_version_c;
                got.ver_d        = i_version_d;
                if (expected_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("%0t: result transaction with none expected, status %0d",
                                 $time, i_status);
                    end
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("%0t: mismatch exp st=%0d ext=%0d man=%h fam=%h mod=%h ver=%h %h %h %h",
                                     $time, want.status, want.man_ext, want.manufacturer,
                                     want.family, want.model, want.ver_a, want.ver_b,
                                     want.ver_c, want.ver_d);
                            $display("%0t: mismatch got st=%0d ext=%0d man=%h fam=%h mod=%h ver=%h %h %h %h",
                                     $time, got.status, got.man_ext, got.manufacturer,
                                     got.family, got.model, got.ver_a, got.ver_b,
                                     got.ver_c, got.ver_d);
                        end
                    end
                end
            end
            if (i_byte_valid && !i_byte_stall) begin
                parse_byte(i_midi_byte);
            end
        end
        o_pending    <= expected_q.size();
        o_fail_count <= fails;
    end

endmodule

FILE: tb/tb_midi_sysex_identity_parser.sv
`timescale 1ns / 100ps

module tb_midi_sysex_identity_parser;
    import msip_pkg::*;

    localparam int ITEMS       = 1950;
    localparam int HOLD_CYCLES = 400;

    // idle bytes, F7 alone, then a normal-form reply with extreme fields,
    // a real-time byte and a second F0 inside it and a non-F7 terminator
    localparam logic [8*21-1:0] DIRECTED_SEQ = {
        8'h00, 8'hFF, 8'h90, 8'hF7,
        8'hF0, 8'h7E, 8'h7F, 8'hF8, 8'h06, 8'h02, 8'h7F, 8'hF0, 8'h7F,
        8'h7F, 8'h00, 8'h7F, 8'h7F, 8'h00, 8'h7F, 8'h00, 8'h80
    };

    typedef enum {
        MSG_REPLY,
        MSG_SHORT,
        MSG_BAD_HDR,
        MSG_NOISE,
        MSG_OVERFLOW
    } t_msg_kind;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_midi_byte = 8'h00;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_status;
    logic        o_man_extended;
    logic [13:0] o_manufacturer;
    logic [13:0] o_family;
    logic [13:0] o_model;
    logic [6:0]  o_version_a;
    logic [6:0]  o_version_b;
    logic [6:0]  o_version_c;
    logic [6:0]  o_version_d;

    int   fail_count;
    int   pending;
    int   bytes_sent = 0;
    logic quiet = 1'b0;
    logic hold_req = 1'b0;

    always #5 i_clk = ~i_clk;

    midi_sysex_identity_parser #(
        .BUFFER_DEPTH(BUFFER_DEPTH_DEF)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_midi_byte    (i_midi_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_man_extended (o_man_extended),
        .o_manufacturer (o_manufacturer),
        .o_family       (o_family),
        .o_model        (o_model),
        .o_version_a    (o_version_a),
        .o_version_b    (o_version_b),
        .o_version_c    (o_version_c),
        .o_version_d    (o_version_d)
    );

    msip_reply_checker #(
        .DEPTH(BUFFER_DEPTH_DEF)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_byte_valid   (i_valid),
        .i_byte_stall   (o_stall),
        .i_midi_byte    (i_midi_byte),
        .i_res_valid    (o_valid),
        .i_res_stall    (i_stall),
        .i_status       (o_status),
        .i_man_extended (o_man_extended),
        .i_manufacturer (o_manufacturer),
        .i_family       (o_family),
        .i_model        (o_model),
        .i_version_a    (o_version_a),
        .i_version_b    (o_version_b),
        .i_version_c    (o_version_c),
        .i_version_d    (o_version_d),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    function automatic logic [7:0] rand7();
        return 8'($urandom_range(0, 127));
    endfunction

    function automatic logic [7:0] end_byte();
        logic [7:0] b;
        if ($urandom_range(0, 3) != 0) begin
            return B_EOX;
        end
        b = 8'($urandom_range(8'h80, 8'hF6));
        return (b == B_SOX) ? B_EOX : b;
    endfunction

    // leaves i_valid high; the caller offers the next byte in the same step
    task automatic send_byte(input logic [7:0] b);
        while (!quiet && $urandom_range(0, 99) < 19) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_midi_byte <= b;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic send_message(input t_msg_kind kind);
        logic [7:0] body[$];
        int         cut;
        case (kind)
            MSG_REPLY, MSG_SHORT, MSG_BAD_HDR: begin
                body.push_back(B_SOX);
                body.push_back(B_NONRT);
                body.push_back(B_BCAST);
                body.push_back(B_GENINFO);
                body.push_back(B_IDREPLY);
                if ($urandom_range(0, 1) == 1) begin
                    body.push_back(B_MAN3);
                    body.push_back(rand7());
                    body.push_back(rand7());
                end else begin
                    body.push_back(8'($urandom_range(1, 127)));
                end
                repeat (8) body.push_back(rand7());
                if (kind == MSG_REPLY && $urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 4)) body.push_back(rand7());
                end
                if (kind == MSG_SHORT) begin
                    cut = $urandom_range(1, body.size() - 1);
                    while (body.size() > cut) void'(body.pop_back());
                end
                if (kind == MSG_BAD_HDR) begin
                    body[$urandom_range(1, 4)] = rand7();
                end
                body.push_back(end_byte());
            end
            MSG_NOISE: begin
                repeat ($urandom_range(1, 8)) body.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
                // runs past the buffer end, or stops at or just short of it
                body.push_back(B_SOX);
                repeat ($urandom_range(125, 132)) body.push_back(rand7());
                body.push_back(end_byte());
            end
        endcase
        foreach (body[i]) begin
            if (i > 0 && $urandom_range(0, 99) < 4) begin
                send_byte(($urandom_range(0, 99) < 70) ? 8'($urandom_range(8'hF8, 8'hFF))
                                                        : B_SOX);
            end
            send_byte(body[i]);
        end
        bytes_sent += body.size();
    endtask

    // receiver holds off while a burst of bare F7 messages piles up results
    task automatic force_backpressure();
        hold_req <= 1'b1;
        send_byte(B_EOX);
        hold_req <= 1'b0;
        repeat (7) send_byte(B_EOX);
        bytes_sent += 8;
    endtask

    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !quiet && ($urandom_range(0, 99) < 19);
            end
        end
    end

    initial begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int        r;
        logic      held;
        t_msg_kind kind;
        held = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 20; i >= 0; i--) begin
            send_byte(DIRECTED_SEQ[i*8 +: 8]);
        end
        bytes_sent = 21;
        drain_results();

        send_message(MSG_OVERFLOW);
        while (bytes_sent < ITEMS) begin
            if (!held && bytes_sent >= 700) begin
                force_backpressure();
                drain_results();
                held = 1'b1;
            end
            quiet <= (bytes_sent >= 1100 && bytes_sent < 1500);
            r = $urandom_range(0, 99);
            if (r < 45) begin
                kind = MSG_REPLY;
            end else if (r < 60) begin
                kind = MSG_SHORT;
            end else if (r < 75) begin
                kind = MSG_BAD_HDR;
            end else if (r < 97) begin
                kind = MSG_NOISE;
            end else begin
                kind = MSG_OVERFLOW;
            end
            send_message(kind);
        end

        drain_results();
        repeat (30) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
